FILE: hw/rtl/sw_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the stopwatch with laps and alarm.
// No dependencies; imported by every module of the block.
package sw_pkg;

    localparam int LAP_DEPTH_DEFAULT = 32;

    localparam int ELAPSED_W = 31;
    localparam int STEP_W    = 23;
    localparam int SEL_W     = 5;
    localparam int SERIAL_W  = 32;
    localparam int STORED_W  = 6;

    localparam logic [ELAPSED_W-1:0] MS_MAX        = {ELAPSED_W{1'b1}};
    localparam logic [ELAPSED_W-1:0] ALARM_DEFAULT = ELAPSED_W'(25000);

    localparam int MS_MOD      = 10;
    localparam int CENTIS_MOD  = 100;
    localparam int SECONDS_MOD = 60;
    localparam int MINUTES_MOD = 60;
    localparam int HOURS_MOD   = 99;

    typedef enum logic [2:0] {
        ACT_TICK   = 3'd0,
        ACT_TOGGLE = 3'd1,
        ACT_RESET  = 3'd2,
        ACT_LAP    = 3'd3,
        ACT_ADJUST = 3'd4,
        ACT_READ   = 3'd5
    } action_t;

    typedef struct packed {
        logic inc;
        logic clr;
    } digit_ctrl_t;

    typedef struct packed {
        logic [STORED_W-1:0]  laps_stored;
        logic [SERIAL_W-1:0]  lap_serial;
        logic                 lap_valid;
        logic [ELAPSED_W-1:0] lap_value;
        logic [6:0]           centis_digit;
        logic [5:0]           seconds_digit;
        logic [5:0]           minutes_digit;
        logic [6:0]           hours_digit;
        logic [ELAPSED_W-1:0] alarm_time;
        logic                 alarm_reached;
        logic                 is_running;
        logic [ELAPSED_W-1:0] elapsed_total;
    } result_t;

endpackage

FILE: hw/rtl/stopwatch_with_laps_and_alarm.sv
`timescale 1ns / 1ps
// Millisecond stopwatch with lap store and alarm; top level of the block.
// Depends on sw_pkg, sw_digit_cell and sw_lap_cell.
//
// Each input beat carries one action and yields exactly one result beat that describes the
// state after the action. The block takes one beat per cycle while s_tready is high; each
// result is registered in the output register, or in the skid register during a stall. The
// display digits come from a chain of modulo counter cells that advance with each counted
// tick, and laps shift through a row of LAP_DEPTH cells. An output register plus a skid
// register keep input acceptance going for one more beat while the result side stalls. Lap
// entries are not cleared at reset; only entries below the stored-lap count are ever read.
module stopwatch_with_laps_and_alarm
    import sw_pkg::*;
#(
    parameter int LAP_DEPTH = LAP_DEPTH_DEFAULT
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // [22:0] alarm_step, [27:23] lap_select, [31:28] zero
    input  logic [31:0]  s_tdata,
    // [2:0] action
    input  logic [2:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [30:0] elapsed_total, [31] is_running, [32] alarm_reached, [63:33] alarm_time,
    // [70:64] hours_digit, [76:71] minutes_digit, [82:77] seconds_digit,
    // [89:83] centis_digit, [120:90] lap_value, [121] lap_valid,
    // [153:122] lap_serial, [159:154] laps_stored
    output logic [159:0] m_tdata
);

    localparam int FILL_W = $clog2(LAP_DEPTH + 1);
    localparam int CMP_W  = (FILL_W > SEL_W) ? FILL_W : SEL_W;
    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(LAP_DEPTH);

    action_t                 action;
    logic [STEP_W-1:0]       alarm_step;
    logic [SEL_W-1:0]        lap_select;
    logic                    accept;

    logic [ELAPSED_W-1:0]    elapsed_reg, elapsed_next;
    logic                    run_reg, run_next;
    logic [ELAPSED_W-1:0]    alarm_reg, alarm_next;
    logic [FILL_W-1:0]       fill_reg, fill_next;
    logic [SERIAL_W-1:0]     serial_reg, serial_next;

    logic                    count_en;
    logic                    clear_en;
    logic                    lap_en;
    logic [ELAPSED_W+1:0]    alarm_sum;

    digit_ctrl_t             ctrl_ms, ctrl_cs, ctrl_sec, ctrl_min, ctrl_hr;
    logic                    carry_ms, carry_cs, carry_sec, carry_min;
    logic [3:0]              ms_next;
    logic [6:0]              cs_next;
    logic [5:0]              sec_next;
    logic [5:0]              min_next;
    logic [6:0]              hr_next;

    logic [ELAPSED_W-1:0]    lap_q [LAP_DEPTH];
    logic [ELAPSED_W-1:0]    lap_read;
    logic                    lap_valid;

    result_t                 result;
    logic                    out_valid_reg;
    result_t                 out_data_reg;
    logic                    skid_valid_reg;
    result_t                 skid_data_reg;

    assign action     = action_t'(s_tuser);
    assign alarm_step = s_tdata[STEP_W-1:0];
    assign lap_select = s_tdata[STEP_W+SEL_W-1:STEP_W];

    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;

    assign count_en = accept && (action == ACT_TICK) && run_reg && (elapsed_reg != MS_MAX);
    assign clear_en = accept && (action == ACT_RESET);
    assign lap_en   = accept && (action == ACT_LAP);

    assign alarm_sum = {2'b00, alarm_reg}
                     + {{(ELAPSED_W + 2 - STEP_W){alarm_step[STEP_W-1]}}, alarm_step};

    always_comb begin
        elapsed_next = elapsed_reg;
        run_next     = run_reg;
        alarm_next   = alarm_reg;
        fill_next    = fill_reg;
        serial_next  = serial_reg;
        if (accept) begin
            case (action)
                ACT_TICK: begin
                    if (count_en) begin
                        elapsed_next = elapsed_reg + ELAPSED_W'(1);
                    end
                end
                ACT_TOGGLE: begin
                    run_next = !run_reg;
                end
                ACT_RESET: begin
                    elapsed_next = '0;
                    alarm_next   = ALARM_DEFAULT;
                    fill_next    = '0;
                    serial_next  = '0;
                end
                ACT_LAP: begin
                    serial_next = serial_reg + SERIAL_W'(1);
                    if (fill_reg != FILL_MAX) begin
                        fill_next = fill_reg + FILL_W'(1);
                    end
                end
                ACT_ADJUST: begin
                    if (alarm_sum[ELAPSED_W+1:ELAPSED_W] == 2'b00) begin
                        alarm_next = alarm_sum[ELAPSED_W-1:0];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            elapsed_reg <= '0;
            run_reg     <= 1'b0;
            alarm_reg   <= ALARM_DEFAULT;
            fill_reg    <= '0;
            serial_reg  <= '0;
        end else begin
            elapsed_reg <= elapsed_next;
            run_reg     <= run_next;
            alarm_reg   <= alarm_next;
            fill_reg    <= fill_next;
            serial_reg  <= serial_next;
        end
    end

    assign ctrl_ms  = '{inc: count_en,  clr: clear_en};
    assign ctrl_cs  = '{inc: carry_ms,  clr: clear_en};
    assign ctrl_sec = '{inc: carry_cs,  clr: clear_en};
    assign ctrl_min = '{inc: carry_sec, clr: clear_en};
    assign ctrl_hr  = '{inc: carry_min, clr: clear_en};

    sw_digit_cell #(.MODULUS(MS_MOD), .WIDTH(4)) u_ms (
        .aclk(aclk), .aresetn(aresetn), .ctrl(ctrl_ms),
        .count_next(ms_next), .carry_o(carry_ms)
    );

    sw_digit_cell #(.MODULUS(CENTIS_MOD), .WIDTH(7)) u_cs (
        .aclk(aclk), .aresetn(aresetn), .ctrl(ctrl_cs),
        .count_next(cs_next), .carry_o(carry_cs)
    );

    sw_digit_cell #(.MODULUS(SECONDS_MOD), .WIDTH(6)) u_sec (
        .aclk(aclk), .aresetn(aresetn), .ctrl(ctrl_sec),
        .count_next(sec_next), .carry_o(carry_sec)
    );

    sw_digit_cell #(.MODULUS(MINUTES_MOD), .WIDTH(6)) u_min (
        .aclk(aclk), .aresetn(aresetn), .ctrl(ctrl_min),
        .count_next(min_next), .carry_o(carry_min)
    );

    sw_digit_cell #(.MODULUS(HOURS_MOD), .WIDTH(7)) u_hr (
        .aclk(aclk), .aresetn(aresetn), .ctrl(ctrl_hr),
        .count_next(hr_next), .carry_o()
    );

    for (genvar i = 0; i < LAP_DEPTH; i++) begin : g_lap
        if (i == 0) begin : g_head
            sw_lap_cell u_cell (
                .aclk(aclk), .shift_en(lap_en), .din(elapsed_reg), .dout(lap_q[i])
            );
        end else begin : g_body
            sw_lap_cell u_cell (
                .aclk(aclk), .shift_en(lap_en), .din(lap_q[i-1]), .dout(lap_q[i])
            );
        end
    end

    always_comb begin
        lap_read = '0;
        for (int i = 0; i < LAP_DEPTH; i++) begin
            if (CMP_W'(lap_select) == CMP_W'(i)) begin
                lap_read = lap_read | lap_q[i];
            end
        end
    end

    assign lap_valid = CMP_W'(lap_select) < CMP_W'(fill_next);

    always_comb begin
        result.elapsed_total = elapsed_next;
        result.is_running    = run_next;
        result.alarm_reached = elapsed_next >= alarm_next;
        result.alarm_time    = alarm_next;
        result.hours_digit   = hr_next;
        result.minutes_digit = min_next;
        result.seconds_digit = sec_next;
        result.centis_digit  = cs_next;
        result.lap_value     = ((action == ACT_READ) && lap_valid) ? lap_read : '0;
        result.lap_valid     = lap_valid;
        result.lap_serial    = serial_next;
        result.laps_stored   = STORED_W'(fill_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (m_tready || !out_valid_reg) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= accept;
            end
        end else if (accept) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (m_tready || !out_valid_reg) begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : result;
        end else if (accept) begin
            skid_data_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

FILE: hw/rtl/sw_digit_cell.sv
`timescale 1ns / 1ps
// One modulo counter cell of the elapsed-time digit chain.
// Depends on sw_pkg; passes a carry to the next cell of the chain.
module sw_digit_cell
    import sw_pkg::*;
#(
    parameter int MODULUS = 10,
    parameter int WIDTH   = $clog2(MODULUS)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  digit_ctrl_t      ctrl,
    output logic [WIDTH-1:0] count_next,
    output logic             carry_o
);

    localparam logic [WIDTH-1:0] LAST = WIDTH'(MODULUS - 1);

    logic [WIDTH-1:0] count_reg;

    assign carry_o = ctrl.inc && (count_reg == LAST);

    always_comb begin
        count_next = count_reg;
        if (ctrl.clr) begin
            count_next = '0;
        end else if (ctrl.inc) begin
            count_next = (count_reg == LAST) ? '0 : count_reg + WIDTH'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

endmodule

FILE: hw/rtl/sw_lap_cell.sv
`timescale 1ns / 1ps
// One entry of the newest-first lap shift store.
// Depends on sw_pkg; takes its input entry (the previous cell's, or the elapsed time for the first cell) on every lap.
module sw_lap_cell
    import sw_pkg::*;
(
    input  logic                 aclk,
    input  logic                 shift_en,
    input  logic [ELAPSED_W-1:0] din,
    output logic [ELAPSED_W-1:0] dout
);

    logic [ELAPSED_W-1:0] entry_reg;

    assign dout = entry_reg;

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            entry_reg <= din;
        end
    end

endmodule

FILE: tb/sv/stopwatch_with_laps_and_alarm_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for stopwatch_with_laps_and_alarm: streams action beats in,
// predicts every result beat from its own stopwatch state and compares field by field.
// Depends on sw_pkg and the block's RTL.
module stopwatch_with_laps_and_alarm_tb
    import sw_pkg::*;
();

    localparam logic [2:0] ACT_SPARE_A = 3'd6;
    localparam logic [2:0] ACT_SPARE_B = 3'd7;

    localparam int DEPTH            = LAP_DEPTH_DEFAULT;
    localparam int RANDOM_ITEMS     = 150;
    localparam int LONG_RUN_TICKS   = 1005;
    localparam int SINK_HOLD_AT     = 400;
    localparam int SINK_HOLD_CYCLES = 300;
    localparam int DRAIN_AT         = 900;
    localparam int CLIMB_STEPS      = 511;

    localparam int unsigned MS_PER_HOUR   = 3600000;
    localparam int unsigned MS_PER_MINUTE = 60000;
    localparam int unsigned MS_PER_SECOND = 1000;

    localparam logic signed [22:0] STEP_MAX = 23'h3FFFFF;
    localparam logic signed [22:0] STEP_MIN = 23'h400000;

    typedef struct {
        logic [2:0]         act;
        logic signed [22:0] delta;
        logic [4:0]         sel;
    } sw_cmd_t;

    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [31:0]  s_tdata  = '0;
    logic [2:0]   s_tuser  = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [159:0] m_tdata;

    sw_cmd_t cmd_backlog[$];
    result_t due_results[$];
    sw_cmd_t cur_cmd;
    result_t mon_want;
    result_t mon_got;

    int items_total;
    int items_sent;
    int results_seen;
    int mismatches;
    int calm_from;
    int src_gap;
    int sink_gap;
    int sink_hold;
    bit drained;
    bit sink_held;
    bit gen_running;

    logic [30:0] sw_elapsed;
    logic [30:0] sw_alarm;
    logic        sw_running;
    logic [30:0] sw_laps[DEPTH];
    int          sw_fill;
    logic [31:0] sw_serial;

    stopwatch_with_laps_and_alarm DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #10 aclk = ~aclk;

    function automatic result_t step_stopwatch(sw_cmd_t c);
        result_t     r;
        longint      na;
        int unsigned e;
        case (c.act)
            ACT_TICK: begin
                if (sw_running && sw_elapsed != MS_MAX)
                    sw_elapsed = sw_elapsed + 1'b1;
            end
            ACT_TOGGLE: begin
                sw_running = !sw_running;
            end
            ACT_RESET: begin
                sw_elapsed = '0;
                sw_fill    = 0;
                sw_serial  = '0;
                sw_alarm   = ALARM_DEFAULT;
            end
            ACT_LAP: begin
                for (int i = DEPTH - 1; i > 0; i--)
                    sw_laps[i] = sw_laps[i - 1];
                sw_laps[0] = sw_elapsed;
                sw_serial  = sw_serial + 1'b1;
                if (sw_fill < DEPTH)
                    sw_fill++;
            end
            ACT_ADJUST: begin
                na = longint'(sw_alarm) + longint'(c.delta);
                if (na >= 0 && na <= longint'(MS_MAX))
                    sw_alarm = na[30:0];
            end
            default: ;
        endcase
        e = 32'(sw_elapsed);
        r = '0;
        r.elapsed_total = sw_elapsed;
        r.is_running    = sw_running;
        r.alarm_reached = (sw_elapsed >= sw_alarm);
        r.alarm_time    = sw_alarm;
        r.hours_digit   = 7'((e / MS_PER_HOUR) % HOURS_MOD);
        r.minutes_digit = 6'((e / MS_PER_MINUTE) % MINUTES_MOD);
        r.seconds_digit = 6'((e / MS_PER_SECOND) % SECONDS_MOD);
        r.centis_digit  = 7'((e / MS_MOD) % CENTIS_MOD);
        r.lap_valid     = (int'(c.sel) < sw_fill);
        if (c.act == ACT_READ && r.lap_valid)
            r.lap_value = sw_laps[c.sel];
        r.lap_serial    = sw_serial;
        r.laps_stored   = 6'(sw_fill);
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    task automatic queue_cmd(logic [2:0] act, logic signed [22:0] delta = '0,
                             logic [4:0] sel = '0);
        sw_cmd_t c;
        c.act   = act;
        c.delta = delta;
        c.sel   = sel;
        if (act == ACT_TOGGLE)
            gen_running = !gen_running;
        cmd_backlog.push_back(c);
    endtask

    function automatic logic signed [22:0] any_delta();
        case ($urandom_range(0, 5))
            0:       return STEP_MAX;
            1:       return STEP_MIN;
            2:       return 23'(int'($urandom_range(0, 2000)) - 1000);
            default: return 23'($urandom);
        endcase
    endfunction

    function automatic logic [4:0] any_sel();
        if ($urandom_range(0, 1))
            return 5'($urandom_range(0, 3));
        return 5'($urandom);
    endfunction

    task automatic queue_random_scenario();
        int n;
        case ($urandom_range(0, 9))
            0, 1: begin
                if (!gen_running)
                    queue_cmd(ACT_TOGGLE);
                n = $urandom_range(5, 80);
                repeat (n) queue_cmd(ACT_TICK);
                if ($urandom_range(0, 2) == 0)
                    queue_cmd(ACT_TOGGLE);
            end
            2, 3: begin
                n = $urandom_range(1, 12);
                repeat (n) begin
                    repeat ($urandom_range(0, 4)) queue_cmd(ACT_TICK);
                    queue_cmd(ACT_LAP, any_delta(), any_sel());
                end
                repeat ($urandom_range(1, 6)) queue_cmd(ACT_READ, any_delta(), any_sel());
            end
            4: begin
                // overfill the store, then read it at random selectors
                repeat ($urandom_range(33, 40)) begin
                    queue_cmd(ACT_TICK);
                    queue_cmd(ACT_LAP);
                end
                repeat ($urandom_range(4, 10))
                    queue_cmd(ACT_READ, any_delta(), 5'($urandom));
            end
            5: begin
                if ($urandom_range(0, 1)) begin
                    // pull the alarm down to zero or just above it, then count through it
                    queue_cmd(ACT_RESET, any_delta(), any_sel());
                    queue_cmd(ACT_ADJUST, 23'(int'($urandom_range(0, 60)) - 25000));
                    if (!gen_running)
                        queue_cmd(ACT_TOGGLE);
                    repeat ($urandom_range(0, 80)) queue_cmd(ACT_TICK);
                end else begin
                    repeat ($urandom_range(2, 8)) begin
                        queue_cmd(ACT_ADJUST, 23'(int'($urandom_range(0, 1000)) - 500));
                        repeat ($urandom_range(0, 6)) queue_cmd(ACT_TICK);
                    end
                end
            end
            6: begin
                repeat ($urandom_range(1, 10)) queue_cmd(ACT_READ, any_delta(), any_sel());
            end
            7: begin
                repeat ($urandom_range(1, 15))
                    queue_cmd(3'($urandom), 23'($urandom), 5'($urandom));
            end
            8: begin
                repeat ($urandom_range(1, 8)) queue_cmd(ACT_ADJUST, any_delta(), any_sel());
            end
            default: begin
                if (gen_running)
                    queue_cmd(ACT_TOGGLE);
                repeat ($urandom_range(1, 10)) queue_cmd(ACT_TICK, any_delta(), any_sel());
                queue_cmd(ACT_TOGGLE);
            end
        endcase
    endtask

    task automatic queue_alarm_climb();
        longint gap;
        gap = longint'(MS_MAX) - longint'(ALARM_DEFAULT) - CLIMB_STEPS * longint'(STEP_MAX);
        queue_cmd(ACT_RESET);
        repeat (CLIMB_STEPS) queue_cmd(ACT_ADJUST, STEP_MAX, any_sel());
        queue_cmd(ACT_ADJUST, STEP_MAX);
        queue_cmd(ACT_ADJUST, 23'(gap));
        queue_cmd(ACT_ADJUST, 23'sd1);
        queue_cmd(ACT_ADJUST, -23'sd1);
        queue_cmd(ACT_ADJUST, 23'sd1);
        queue_cmd(ACT_RESET);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                due_results.push_back(step_stopwatch(cur_cmd));
                items_sent++;
            end
            if (!s_tvalid || s_tready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_tvalid <= 1'b0;
                end else if (items_sent == DRAIN_AT && !drained) begin
                    // hold off until every outstanding result is back
                    s_tvalid <= 1'b0;
                    if (due_results.size() == 0)
                        drained = 1'b1;
                end else if (cmd_backlog.size() > 0) begin
                    cur_cmd = cmd_backlog.pop_front();
                    s_tdata  <= {4'b0, cur_cmd.sel, cur_cmd.delta};
                    s_tuser  <= cur_cmd.act;
                    s_tvalid <= 1'b1;
                    if (items_sent < calm_from && $urandom_range(0, 9) == 0)
                        src_gap = $urandom_range(1, 14);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (due_results.size() == 0) begin
                    $error("result beat with no expected result waiting");
                    mismatches++;
                end else begin
                    mon_want = due_results.pop_front();
                    mon_got  = result_t'(m_tdata);
                    check_field("elapsed_total", mon_want.elapsed_total, mon_got.elapsed_total);
                    check_field("is_running", mon_want.is_running, mon_got.is_running);
                    check_field("alarm_reached", mon_want.alarm_reached, mon_got.alarm_reached);
                    check_field("alarm_time", mon_want.alarm_time, mon_got.alarm_time);
                    check_field("hours_digit", mon_want.hours_digit, mon_got.hours_digit);
                    check_field("minutes_digit", mon_want.minutes_digit, mon_got.minutes_digit);
                    check_field("seconds_digit", mon_want.seconds_digit, mon_got.seconds_digit);
                    check_field("centis_digit", mon_want.centis_digit, mon_got.centis_digit);
                    check_field("lap_value", mon_want.lap_value, mon_got.lap_value);
                    check_field("lap_valid", mon_want.lap_valid, mon_got.lap_valid);
                    check_field("lap_serial", mon_want.lap_serial, mon_got.lap_serial);
                    check_field("laps_stored", mon_want.laps_stored, mon_got.laps_stored);
                end
            end
            if (sink_hold > 0) begin
                sink_hold--;
                m_tready <= 1'b0;
            end else if (!sink_held && results_seen >= SINK_HOLD_AT) begin
                // stall the result side long enough to back up the input
                sink_held = 1'b1;
                sink_hold = SINK_HOLD_CYCLES - 1;
                m_tready <= 1'b0;
            end else if (sink_gap > 0) begin
                sink_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (items_sent < calm_from && $urandom_range(0, 11) == 0)
                    sink_gap = $urandom_range(1, 14);
            end
        end
    end

    initial begin
        sw_elapsed = '0;
        sw_running = 1'b0;
        sw_alarm   = ALARM_DEFAULT;
        sw_fill    = 0;
        sw_serial  = '0;
        foreach (sw_laps[i]) sw_laps[i] = '0;

        calm_from = 1 << 30;
        queue_cmd(ACT_READ, '0, 5'd0);
        queue_cmd(ACT_READ, '0, 5'd31);
        queue_cmd(ACT_TICK);
        queue_cmd(ACT_TOGGLE);
        repeat (10) queue_cmd(ACT_TICK);
        queue_cmd(ACT_LAP);
        queue_cmd(ACT_READ, '0, 5'd0);
        queue_cmd(ACT_READ, '0, 5'd1);
        queue_cmd(ACT_ADJUST, STEP_MIN);
        queue_cmd(ACT_ADJUST, -23'sd25000);
        queue_cmd(ACT_ADJUST, STEP_MAX);
        queue_cmd(ACT_ADJUST, STEP_MIN);
        queue_cmd(ACT_SPARE_A, -23'sd1, 5'd31);
        queue_cmd(ACT_SPARE_B, -23'sd1, 5'd31);
        queue_cmd(ACT_RESET);
        queue_cmd(ACT_TOGGLE);

        while (cmd_backlog.size() < RANDOM_ITEMS / 2)
            queue_random_scenario();
        queue_alarm_climb();
        while (cmd_backlog.size() < RANDOM_ITEMS + CLIMB_STEPS)
            queue_random_scenario();

        // long counting stretch across the seconds carry, with no random gaps on either side
        calm_from = cmd_backlog.size();
        if (!gen_running)
            queue_cmd(ACT_TOGGLE);
        queue_cmd(ACT_RESET);
        repeat (LONG_RUN_TICKS) queue_cmd(ACT_TICK);
        queue_cmd(ACT_LAP);
        queue_cmd(ACT_READ, '0, 5'd0);
        queue_cmd(ACT_TOGGLE);
        queue_cmd(ACT_TICK);
        items_total = cmd_backlog.size();

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        while (items_sent < items_total || due_results.size() > 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
